/* rtl/cqr_pkg.sv */
`default_nettype none

package cqr_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned K_W    = 5;
  localparam int unsigned OCC_W  = 5;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned CMP_W  = (CNT_W > K_W) ? CNT_W : K_W;

  localparam logic [DATA_W-1:0] POP_EMPTY = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ   = 2'd0,
    CMD_DEQ   = 2'd1,
    CMD_REV   = 2'd2,
    CMD_ILEAV = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_EMPTY = 3'd2,
    ST_BADK  = 3'd3,
    ST_ODD   = 3'd4
  } status_e;

endpackage

`default_nettype wire

/* rtl/circular_queue_reorder_core.sv */
`default_nettype none

// Channel | Direction | Handshake                 | Payload
// in      | input     | in_valid_i / in_stall_o   | cmd_i, push_value_i, reverse_count_i
// out     | output    | out_valid_o / out_stall_i | pop_value_o, status_o, occupancy_o
//
// Enqueue, rejected commands and an empty interleave go to S_RESP, which loads the
// result; dequeue reads the store in S_POP first. Reverse of k entries or interleave
// the whole queue runs S_COPY, then S_WBACK: each entry is copied out to a scratch
// RAM and written back permuted, one per cycle, bounded by each RAM's one read port.
// Reset clears head, tail, count and handshake state; the store is not cleared.
// in_stall_o is high from accept until the result is loaded; a stalled result waits
// in the output register while the next item is accepted.

module circular_queue_reorder_core
  import cqr_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [CMD_W-1:0]         cmd_i,
  input  wire logic signed [DATA_W-1:0] push_value_i,
  input  wire logic [K_W-1:0]           reverse_count_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic signed [DATA_W-1:0]      pop_value_o,
  output logic [STAT_W-1:0]             status_o,
  output logic [OCC_W-1:0]              occupancy_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_COPY,
    S_WBACK,
    S_RESP
  } state_e;

  state_e              state_q;
  logic [IDX_W-1:0]    head_q;
  logic [IDX_W-1:0]    tail_q;
  logic [CNT_W-1:0]    count_q;
  logic [CNT_W-1:0]    n_q;
  logic [CNT_W-1:0]    j_q;
  logic [CNT_W-1:0]    pw_idx_q;
  logic                pw_valid_q;
  logic                is_rev_q;
  logic [DATA_W-1:0]   res_pop_q;
  status_e             res_status_q;

  logic                accept;
  logic                full;
  logic                empty;
  logic [CMP_W-1:0]    k_ext;
  logic [CMP_W-1:0]    cnt_ext;
  logic [CNT_W-1:0]    perm;
  logic                more;

  logic                st_we;
  logic [IDX_W-1:0]    st_waddr;
  logic [DATA_W-1:0]   st_wdata;
  logic                st_re;
  logic [IDX_W-1:0]    st_raddr;
  logic [DATA_W-1:0]   st_rdata;
  logic                sc_we;
  logic [IDX_W-1:0]    sc_waddr;
  logic                sc_re;
  logic [IDX_W-1:0]    sc_raddr;
  logic [DATA_W-1:0]   sc_rdata;

  // physical index of the entry at offset off from the head
  function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] head,
                                            input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(head) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(DEPTH)) begin
      sum = sum - (CNT_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] bump(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CNT_W'(DEPTH));
  assign empty      = (count_q == '0);
  assign k_ext      = CMP_W'(reverse_count_i);
  assign cnt_ext    = CMP_W'(count_q);
  assign more       = (j_q < n_q);

  // write-back order: reversed block, or a1,b1,a2,b2,...
  always_comb begin
    if (is_rev_q) begin
      perm = n_q - 1'b1 - j_q;
    end else if (j_q[0]) begin
      perm = (n_q >> 1) + (j_q >> 1);
    end else begin
      perm = j_q >> 1;
    end
  end

  always_comb begin
    st_we    = 1'b0;
    st_waddr = tail_q;
    st_wdata = push_value_i;
    st_re    = 1'b0;
    st_raddr = head_q;
    sc_we    = 1'b0;
    sc_waddr = pw_idx_q[IDX_W-1:0];
    sc_re    = 1'b0;
    sc_raddr = perm[IDX_W-1:0];
    case (state_q)
      S_IDLE: begin
        if (accept && (cmd_i == CMD_ENQ) && !full) begin
          st_we = 1'b1;
        end
        if (accept && (cmd_i == CMD_DEQ) && !empty) begin
          st_re = 1'b1;
        end
      end
      S_COPY: begin
        st_re    = more;
        st_raddr = slot(head_q, j_q);
        sc_we    = pw_valid_q;
      end
      S_WBACK: begin
        sc_re    = more;
        st_we    = pw_valid_q;
        st_waddr = slot(head_q, pw_idx_q);
        st_wdata = sc_rdata;
      end
      default: begin
      end
    endcase
  end

  cqr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  cqr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_scratch (
    .clk_i   (clk_i),
    .we_i    (sc_we),
    .waddr_i (sc_waddr),
    .wdata_i (st_rdata),
    .re_i    (sc_re),
    .raddr_i (sc_raddr),
    .rdata_o (sc_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= '0;
      tail_q       <= '0;
      count_q      <= '0;
      n_q          <= '0;
      j_q          <= '0;
      pw_idx_q     <= '0;
      pw_valid_q   <= 1'b0;
      is_rev_q     <= 1'b0;
      res_pop_q    <= '0;
      res_status_q <= ST_OK;
      out_valid_o  <= 1'b0;
      pop_value_o  <= '0;
      status_o     <= '0;
      occupancy_o  <= '0;
    end else begin
      // S_RESP handles the output register itself
      if (out_valid_o && !out_stall_i && (state_q != S_RESP)) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            res_pop_q    <= '0;
            res_status_q <= ST_OK;
            j_q          <= '0;
            pw_valid_q   <= 1'b0;
            state_q      <= S_RESP;
            case (cmd_e'(cmd_i))
              CMD_ENQ: begin
                if (full) begin
                  res_status_q <= ST_FULL;
                end else begin
                  tail_q  <= bump(tail_q);
                  count_q <= count_q + 1'b1;
                end
              end
              CMD_DEQ: begin
                if (empty) begin
                  res_pop_q    <= POP_EMPTY;
                  res_status_q <= ST_EMPTY;
                end else begin
                  head_q  <= bump(head_q);
                  count_q <= count_q - 1'b1;
                  state_q <= S_POP;
                end
              end
              CMD_REV: begin
                if ((k_ext == '0) || (k_ext > cnt_ext)) begin
                  res_status_q <= ST_BADK;
                end else begin
                  n_q      <= CNT_W'(reverse_count_i);
                  is_rev_q <= 1'b1;
                  state_q  <= S_COPY;
                end
              end
              CMD_ILEAV: begin
                if (count_q[0]) begin
                  res_status_q <= ST_ODD;
                end else if (!empty) begin
                  n_q      <= count_q;
                  is_rev_q <= 1'b0;
                  state_q  <= S_COPY;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_POP: begin
          res_pop_q <= st_rdata;
          state_q   <= S_RESP;
        end
        S_COPY: begin
          // last scratch write lands in the cycle that j_q reaches n_q
          if (more) begin
            j_q        <= j_q + 1'b1;
            pw_idx_q   <= j_q;
            pw_valid_q <= 1'b1;
          end else begin
            j_q        <= '0;
            pw_valid_q <= 1'b0;
            state_q    <= S_WBACK;
          end
        end
        S_WBACK: begin
          if (more) begin
            j_q        <= j_q + 1'b1;
            pw_idx_q   <= j_q;
            pw_valid_q <= 1'b1;
          end else begin
            pw_valid_q <= 1'b0;
            state_q    <= S_RESP;
          end
        end
        S_RESP: begin
          if (!out_valid_o || !out_stall_i) begin
            out_valid_o <= 1'b1;
            pop_value_o <= res_pop_q;
            status_o    <= res_status_q;
            occupancy_o <= OCC_W'(count_q);
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/cqr_ram.sv */
`default_nettype none

module cqr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire
